/* hw/rtl/fire_field_stencil_engine_defines.svh */
// Assertion macros used by the fire field stencil engine controller.
`ifndef FIRE_FIELD_STENCIL_ENGINE_DEFINES_SVH
`define FIRE_FIELD_STENCIL_ENGINE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define FFSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Plain invariant checked at every clock edge outside reset.
`define FFSE_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

`endif

/* hw/rtl/ffse_pkg.sv */
// Shared types, codes and the decay function of the fire field stencil engine.
package ffse_pkg;

    // Action codes of an input transaction.
    typedef enum logic [1:0] {
        ACT_SPARK = 2'd0,
        ACT_STEP  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Decay thresholds and amounts.
    localparam logic [7:0] DECAY_HI_TH   = 8'd128;
    localparam logic [7:0] DECAY_MID_TH  = 8'd12;
    localparam logic [7:0] DECAY_LO_TH   = 8'd8;
    localparam logic [7:0] DECAY_HI_AMT  = 8'd2;
    localparam logic [7:0] DECAY_MID_AMT = 8'd4;
    localparam logic [7:0] DECAY_LO_AMT  = 8'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic spark_wr;
        logic spark_row;
        logic sp_adv;
        logic pass_issue;
        logic rd_addr;
        logic rd_capture;
        logic out_load;
    } ffse_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic sp_stop;
        logic pass_last;
        logic pipe_busy;
    } ffse_sts_t;

    // Lowers an intensity by an amount that depends on its level, never below zero.
    function automatic logic [7:0] decay_f(input logic [7:0] v);
        logic [7:0] res;
        if (v > DECAY_HI_TH) begin
            res = v - DECAY_HI_AMT;
        end else if (v > DECAY_MID_TH) begin
            res = v - DECAY_MID_AMT;
        end else if (v > DECAY_LO_TH) begin
            res = v - DECAY_LO_AMT;
        end else if (v != 8'd0) begin
            res = v - 8'd1;
        end else begin
            res = 8'd0;
        end
        return res;
    endfunction

endpackage

/* hw/rtl/ffse_datapath.sv */
// Datapath: grid memory, line buffer, stencil pipeline, spark and read addressing.
module ffse_datapath #(
    parameter int HEIGHT = 103,
    parameter int WIDTH  = 169
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ffse_pkg::ffse_cmd_t  cmd,
    output ffse_pkg::ffse_sts_t  sts,
    input  logic [7:0]           s_col,
    input  logic [6:0]           s_row,
    input  logic [3:0]           s_span,
    input  logic [7:0]           s_color,
    output logic [7:0]           m_value
);

    localparam int DEPTH = HEIGHT * WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int JW    = $clog2(WIDTH);
    localparam int RW    = $clog2(HEIGHT);
    // Spark column counter must hold a start column plus a full span, and WIDTH.
    localparam int SCW   = $clog2(WIDTH + 272);

    localparam logic [AW-1:0]  ROW_STEP    = AW'(WIDTH);
    localparam logic [AW-1:0]  SEED0_BASE  = AW'((HEIGHT - 3) * WIDTH);
    localparam logic [AW-1:0]  SEED1_BASE  = AW'((HEIGHT - 2) * WIDTH);
    localparam logic [AW-1:0]  PASS_BASE0  = AW'(2 * WIDTH);
    localparam logic [AW-1:0]  UP_OFFSET   = AW'(2 * WIDTH);
    localparam logic [AW-1:0]  DEST_OFFSET = AW'(3 * WIDTH + 1);
    localparam logic [AW-1:0]  CLR_LAST    = AW'(DEPTH - 1);
    localparam logic [JW-1:0]  J_LAST      = JW'(WIDTH - 1);
    localparam logic [JW-1:0]  J_EMIT_MIN  = JW'(2);
    localparam logic [RW-1:0]  R_FIRST     = RW'(1);
    localparam logic [RW-1:0]  R_LAST      = RW'(HEIGHT - 2);
    localparam logic [RW-1:0]  R_EMIT_MIN  = RW'(2);
    localparam logic [SCW-1:0] SP_COL_MAX  = SCW'(WIDTH - 2);

    // Storage.
    logic [7:0] grid_mem [DEPTH];
    logic [7:0] lbuf_mem [WIDTH];

    // Captured transaction fields.
    logic [7:0]     in_col_reg;
    logic [6:0]     in_row_reg;
    logic [7:0]     in_color_reg;

    // Spark walk.
    logic [SCW-1:0] sp_col_reg;
    logic [3:0]     sp_left_reg;

    // Pass walk: base is the address of row r+1, column 0.
    logic [JW-1:0]  pass_j_reg;
    logic [RW-1:0]  pass_r_reg;
    logic [AW-1:0]  pass_base_reg;

    // Single cell read.
    logic [AW-1:0]  rd_addr_reg;
    logic           rd_ok_reg;

    // Clearing pass after reset.
    logic [AW-1:0]  clr_addr_reg;

    // Memory read data (row r+1, row r-1, row r).
    logic [7:0]     ra_reg;
    logic [7:0]     rb_reg;
    logic [7:0]     rl_reg;

    // Stage 1 tags.
    logic           s1_v_reg;
    logic [JW-1:0]  s1_j_reg;
    logic [RW-1:0]  s1_r_reg;
    logic [AW-1:0]  s1_a_reg;

    // Stage 2 window and tags.
    logic [7:0]     w0_reg;
    logic [7:0]     w1_reg;
    logic [7:0]     w2_reg;
    logic [7:0]     lo_p_reg;
    logic [7:0]     lo_c_reg;
    logic [7:0]     up_p_reg;
    logic [7:0]     up_c_reg;
    logic           s2_v_reg;
    logic [JW-1:0]  s2_j_reg;
    logic [RW-1:0]  s2_r_reg;
    logic [AW-1:0]  s2_a_reg;

    // Stage 3 write-back.
    logic           wr_v_reg;
    logic [AW-1:0]  wr_addr_reg;
    logic [7:0]     wr_data_reg;

    // Result.
    logic [7:0]     res_reg;
    logic [7:0]     m_value_reg;

    logic [AW-1:0]  addr_a;
    logic [AW-1:0]  addr_b;
    logic [AW-1:0]  port_a_addr;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    logic [7:0]     mem_wdata;
    logic [9:0]     sum4;
    logic [8:0]     sum2;
    logic [7:0]     cell_new;
    logic           emit;

    // Read addresses for the pass and the shared port A.
    assign addr_a      = pass_base_reg + AW'(pass_j_reg);
    assign addr_b      = addr_a - UP_OFFSET;
    assign port_a_addr = cmd.pass_issue ? addr_a : rd_addr_reg;

    // Write port selection: clearing, spark, then pass write-back.
    always_comb begin
        if (cmd.clr_step) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 8'd0;
        end else if (cmd.spark_wr) begin
            mem_we    = 1'b1;
            mem_waddr = (cmd.spark_row ? SEED1_BASE : SEED0_BASE) + AW'(sp_col_reg);
            mem_wdata = in_color_reg;
        end else begin
            mem_we    = wr_v_reg;
            mem_waddr = wr_addr_reg;
            mem_wdata = wr_data_reg;
        end
    end

    // Grid memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        ra_reg <= grid_mem[port_a_addr];
        rb_reg <= grid_mem[addr_b];
    end

    // Line buffer holds row r; it is refilled from row r+1 as the walk goes.
    always_ff @(posedge aclk) begin
        if (s1_v_reg) begin
            lbuf_mem[s1_j_reg] <= ra_reg;
        end
        rl_reg <= lbuf_mem[pass_j_reg];
    end

    // Control registers: clear counter and pipeline valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            wr_v_reg     <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            s1_v_reg <= cmd.pass_issue;
            s2_v_reg <= s1_v_reg;
            wr_v_reg <= emit;
        end
    end

    // Transaction capture, spark and pass counters, and read address.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            in_col_reg    <= s_col;
            in_row_reg    <= s_row;
            in_color_reg  <= s_color;
            sp_col_reg    <= SCW'(s_col);
            sp_left_reg   <= s_span;
            pass_j_reg    <= '0;
            pass_r_reg    <= R_FIRST;
            pass_base_reg <= PASS_BASE0;
        end else begin
            if (cmd.sp_adv) begin
                sp_col_reg  <= sp_col_reg + SCW'(1);
                sp_left_reg <= sp_left_reg - 4'd1;
            end
            if (cmd.pass_issue) begin
                if (pass_j_reg == J_LAST) begin
                    pass_j_reg    <= '0;
                    pass_r_reg    <= pass_r_reg + RW'(1);
                    pass_base_reg <= pass_base_reg + ROW_STEP;
                end else begin
                    pass_j_reg <= pass_j_reg + JW'(1);
                end
            end
        end
        if (cmd.rd_addr) begin
            rd_addr_reg <= AW'(AW'(in_row_reg) * ROW_STEP) + AW'(in_col_reg);
            rd_ok_reg   <= (int'(in_row_reg) < HEIGHT) && (int'(in_col_reg) < WIDTH);
        end
    end

    // Stage 1 tags follow the issued read.
    always_ff @(posedge aclk) begin
        s1_j_reg <= pass_j_reg;
        s1_r_reg <= pass_r_reg;
        s1_a_reg <= addr_a;
    end

    // Stage 2: slide the window over row r and align upper and lower cells.
    always_ff @(posedge aclk) begin
        if (s1_v_reg) begin
            w0_reg   <= w1_reg;
            w1_reg   <= w2_reg;
            w2_reg   <= rl_reg;
            lo_c_reg <= lo_p_reg;
            lo_p_reg <= ra_reg;
            up_c_reg <= up_p_reg;
            up_p_reg <= rb_reg;
        end
        s2_j_reg <= s1_j_reg;
        s2_r_reg <= s1_r_reg;
        s2_a_reg <= s1_a_reg;
    end

    // Stencil: mean of four, averaged with the upper cell, then decayed.
    assign sum4     = {2'b00, w0_reg} + {2'b00, w1_reg} + {2'b00, w2_reg} + {2'b00, lo_c_reg};
    assign sum2     = {1'b0, sum4[9:2]} + {1'b0, up_c_reg};
    assign cell_new = ffse_pkg::decay_f(sum2[8:1]);
    assign emit     = s2_v_reg && (s2_j_reg >= J_EMIT_MIN) && (s2_r_reg >= R_EMIT_MIN);

    // Stage 3: result goes three rows up, one column left of the issue address.
    always_ff @(posedge aclk) begin
        wr_addr_reg <= s2_a_reg - DEST_OFFSET;
        wr_data_reg <= cell_new;
    end

    // Result value and output register.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_reg <= 8'd0;
        end else if (cmd.rd_capture) begin
            res_reg <= rd_ok_reg ? ra_reg : 8'd0;
        end
        if (cmd.out_load) begin
            m_value_reg <= res_reg;
        end
    end

    assign m_value       = m_value_reg;
    assign sts.clr_last  = (clr_addr_reg == CLR_LAST);
    assign sts.sp_stop   = (sp_left_reg == 4'd0) || (sp_col_reg > SP_COL_MAX);
    assign sts.pass_last = (pass_j_reg == J_LAST) && (pass_r_reg == R_LAST);
    assign sts.pipe_busy = s1_v_reg || s2_v_reg || wr_v_reg;

endmodule

/* hw/rtl/ffse_ctrl.sv */
// Controller: sequences clearing, spark, update pass, read and result hand-off.
`include "fire_field_stencil_engine_defines.svh"

module ffse_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic [1:0]           s_action,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ffse_pkg::ffse_cmd_t  cmd,
    input  ffse_pkg::ffse_sts_t  sts
);

    typedef enum logic [9:0] {
        S_CLEAR     = 10'b00_0000_0001,
        S_IDLE      = 10'b00_0000_0010,
        S_SPARK_A   = 10'b00_0000_0100,
        S_SPARK_B   = 10'b00_0000_1000,
        S_PASS      = 10'b00_0001_0000,
        S_DRAIN     = 10'b00_0010_0000,
        S_READ_ADDR = 10'b00_0100_0000,
        S_READ      = 10'b00_1000_0000,
        S_READ_WAIT = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    // Next state and command decode.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (ffse_pkg::action_t'(s_action))
                        ffse_pkg::ACT_SPARK: state_next = S_SPARK_A;
                        ffse_pkg::ACT_STEP:  state_next = S_PASS;
                        ffse_pkg::ACT_READ:  state_next = S_READ_ADDR;
                        default:             state_next = S_DONE;
                    endcase
                end
            end
            S_SPARK_A: begin
                if (sts.sp_stop) begin
                    state_next = S_DONE;
                end else begin
                    cmd.spark_wr = 1'b1;
                    state_next   = S_SPARK_B;
                end
            end
            S_SPARK_B: begin
                cmd.spark_wr  = 1'b1;
                cmd.spark_row = 1'b1;
                cmd.sp_adv    = 1'b1;
                state_next    = S_SPARK_A;
            end
            S_PASS: begin
                cmd.pass_issue = 1'b1;
                if (sts.pass_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = S_DONE;
                end
            end
            S_READ_ADDR: begin
                cmd.rd_addr = 1'b1;
                state_next  = S_READ;
            end
            S_READ: begin
                state_next = S_READ_WAIT;
            end
            S_READ_WAIT: begin
                cmd.rd_capture = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set when a result is loaded, cleared when it is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // A result is never loaded over one that has not been taken.
    `FFSE_ASSERT_IMP(a_no_overwrite, cmd.out_load, !m_valid_reg || m_ready, "result overwritten")

    // The stencil pipeline has drained before a new transaction can start.
    `FFSE_ASSERT_IMP(a_idle_drained, state_reg == S_IDLE, !sts.pipe_busy, "pipeline busy in idle")

    // Only one grid-changing activity runs at a time.
    `FFSE_ASSERT_ALWAYS(a_one_writer,
        $onehot0({cmd.clr_step, cmd.spark_wr, cmd.pass_issue, cmd.load}),
        "conflicting commands")

endmodule

/* hw/rtl/fire_field_stencil_engine.sv */
// Top level of the fire field stencil engine: controller plus datapath.
// After reset the block clears its HEIGHT*WIDTH grid one cell per cycle
// and accepts no transaction until that is done. A step transaction walks
// rows 1 to HEIGHT-2 in full, one cell per cycle, reading the grid through
// two read ports and a line buffer, then waits for the pipeline to drain.
// A spark transaction writes each cell of its two seed rows in turn through
// the single grid write port. A read transaction computes the address, reads
// the cell and captures it. One transaction is handled at a time; a finished
// result waits in the output register while the next transaction is taken.
module fire_field_stencil_engine #(
    parameter int HEIGHT = 103,
    parameter int WIDTH  = 169
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_action,
    input  logic [7:0] s_col,
    input  logic [6:0] s_row,
    input  logic [3:0] s_span,
    input  logic [7:0] s_color,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_value
);

    ffse_pkg::ffse_cmd_t cmd;
    ffse_pkg::ffse_sts_t sts;

    // Sequencer.
    ffse_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Grid storage and stencil pipeline.
    ffse_datapath #(
        .HEIGHT (HEIGHT),
        .WIDTH  (WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .sts     (sts),
        .s_col   (s_col),
        .s_row   (s_row),
        .s_span  (s_span),
        .s_color (s_color),
        .m_value (m_value)
    );

endmodule

/* bench/fire_field_stencil_engine_test.sv */
// Self-checking testbench for the fire field stencil engine, with its own grid model.
module fire_field_stencil_engine_test;

    localparam int ROWS = 103;
    localparam int COLS = 169;
    localparam int CELLS = ROWS * COLS;

    // One input transaction waiting to be offered, plus a flag to let the block drain first.
    typedef struct {
        ffse_pkg::action_t act;
        logic [7:0]        col;
        logic [6:0]        row;
        logic [3:0]        span;
        logic [7:0]        color;
        bit                drain_first;
    } fire_item_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_action = 2'd0;
    logic [7:0] s_col = 8'd0;
    logic [6:0] s_row = 7'd0;
    logic [3:0] s_span = 4'd0;
    logic [7:0] s_color = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_value;

    fire_item_t item_backlog[$];
    logic [7:0] value_due[$];
    logic [7:0] heat_map[0:CELLS-1];
    logic [7:0] heat_prev[0:CELLS-1];

    logic in_taken = 1'b0;
    int   results_seen = 0;
    int   error_count = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   hold_left = 0;
    bit   hold_done[2] = '{1'b0, 1'b0};
    int   stall_mode = 0;
    int   mode_left = 0;

    fire_field_stencil_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_col    (s_col),
        .s_row    (s_row),
        .s_span   (s_span),
        .s_color  (s_color),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_value  (m_value)
    );

    // Clock and the single reset at the start of the run.
    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5000000;
        $display("fire_field_stencil_engine_test: done, errors");
        $finish;
    end

    // Lowers a cell value by the level-dependent cooling amount.
    function automatic int cool_down(input int v);
        int res;
        if (v > 128) begin
            res = v - 2;
        end else if (v > 12) begin
            res = v - 4;
        end else if (v > 8) begin
            res = v - 2;
        end else if (v > 0) begin
            res = v - 1;
        end else begin
            res = 0;
        end
        return res;
    endfunction

    // Applies one transaction to the grid copy and returns the value it should produce.
    function automatic logic [7:0] fire_apply(input ffse_pkg::action_t act,
                                              input logic [7:0] col,
                                              input logic [6:0] row, input logic [3:0] span,
                                              input logic [7:0] color);
        logic [7:0] value;
        int         c;
        int         r;
        int         mean4;
        int         blend;
        value = 8'd0;
        case (act)
            ffse_pkg::ACT_SPARK: begin
                // The run stops after the last interior column.
                for (c = col; c < col + span && c <= COLS - 2; c++) begin
                    heat_map[(ROWS - 3) * COLS + c] = color;
                    heat_map[(ROWS - 2) * COLS + c] = color;
                end
            end
            ffse_pkg::ACT_STEP: begin
                // Every new cell is computed from the grid as it stood before the pass.
                for (c = 0; c < CELLS; c++) begin
                    heat_prev[c] = heat_map[c];
                end
                for (r = 2; r <= ROWS - 2; r++) begin
                    for (c = 1; c <= COLS - 2; c++) begin
                        mean4 = (heat_prev[r * COLS + c - 1] + heat_prev[r * COLS + c] +
                                 heat_prev[r * COLS + c + 1] + heat_prev[(r + 1) * COLS + c]) >> 2;
                        blend = (mean4 + heat_prev[(r - 1) * COLS + c]) >> 1;
                        heat_map[(r - 2) * COLS + c] = 8'(cool_down(blend));
                    end
                end
            end
            ffse_pkg::ACT_READ: begin
                if (row < ROWS && col < COLS) begin
                    value = heat_map[row * COLS + col];
                end
            end
            default: begin
                value = 8'd0;
            end
        endcase
        return value;
    endfunction

    // Prints one mismatch line and counts it.
    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("fire_field_stencil_engine_test: mismatch, %s: value %0d, expected %0d",
                 what, got, want);
        error_count++;
    endtask

    function automatic void add_item(input ffse_pkg::action_t act, input int col, input int row,
                                     input int span, input int color, input bit drain);
        fire_item_t it;
        it.act = act;
        it.col = col[7:0];
        it.row = row[6:0];
        it.span = span[3:0];
        it.color = color[7:0];
        it.drain_first = drain;
        item_backlog.push_back(it);
    endfunction

    // Spark colors lean hot so that the upper cooling thresholds are crossed often.
    function automatic int hot_color();
        int pick;
        pick = ($urandom_range(0, 1) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 255);
        return pick;
    endfunction

    // Read rows lean toward the band the flames can have reached so far.
    function automatic int flame_row(input int climbed);
        int lo;
        int pick;
        lo = ROWS - 5 - 2 * climbed;
        if (lo < 0) begin
            lo = 0;
        end
        case ($urandom_range(0, 9))
            0: pick = $urandom_range(0, 127);
            1, 2: pick = $urandom_range(0, ROWS - 1);
            default: pick = $urandom_range(lo, ROWS - 1);
        endcase
        return pick;
    endfunction

    // Sender: offers backlog items in bursts, holds each payload until it is taken.
    always @(negedge aclk) begin
        fire_item_t it;
        logic       v_next;
        v_next = s_valid;
        if (aresetn) begin
            if (!s_valid || in_taken) begin
                v_next = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (item_backlog.size() > 0 &&
                             !(item_backlog[0].drain_first && value_due.size() != 0)) begin
                    it = item_backlog.pop_front();
                    s_action <= it.act;
                    s_col <= it.col;
                    s_row <= it.row;
                    s_span <= it.span;
                    s_color <= it.color;
                    v_next = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 5) == 0) begin
                        burst_left = $urandom_range(30, 60);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 6);
                        gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                                : $urandom_range(0, 4);
                    end
                end
            end
        end
        s_valid <= v_next;
    end

    // Receiver: random stall modes, plus two long holds that back the block up.
    always @(negedge aclk) begin
        logic rdy;
        rdy = 1'b0;
        if (aresetn) begin
            if (hold_left > 0) begin
                hold_left--;
            end else if (!hold_done[0] && results_seen >= 3) begin
                hold_done[0] = 1'b1;
                hold_left = 300;
            end else if (!hold_done[1] && results_seen >= 60) begin
                hold_done[1] = 1'b1;
                hold_left = 300;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0: rdy = 1'b1;
                    1: rdy = $urandom_range(0, 1);
                    2: rdy = ($urandom_range(0, 3) != 0);
                    default: rdy = (mode_left % 4 == 0);
                endcase
            end
        end
        m_ready <= rdy;
    end

    // Monitor: predicts each accepted transaction and checks each result in order.
    always @(posedge aclk) begin
        logic [7:0] want;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                value_due.push_back(fire_apply(ffse_pkg::action_t'(s_action), s_col, s_row,
                                               s_span, s_color));
            end
            if (m_valid && m_ready) begin
                if (value_due.size() == 0) begin
                    flag_mismatch("result with nothing outstanding", m_value, 8'd0);
                end else begin
                    want = value_due.pop_front();
                    if (m_value !== want) begin
                        flag_mismatch("value field", m_value, want);
                    end
                end
                results_seen <= results_seen + 1;
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int                n_rand;
        int                steps_left;
        int                climbed;
        int                k;
        bit                drain_next;
        ffse_pkg::action_t act;
        for (k = 0; k < CELLS; k++) begin
            heat_map[k] = 8'd0;
        end

        // Directed: edges of the spark run, border cells, out-of-range reads, unused action.
        add_item(ffse_pkg::ACT_READ, 0, 0, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_SPARK, 1, 0, 10, 255, 1'b0);
        add_item(ffse_pkg::ACT_SPARK, 0, 0, 3, 165, 1'b0);
        add_item(ffse_pkg::ACT_SPARK, 163, 0, 10, 200, 1'b0);
        add_item(ffse_pkg::ACT_SPARK, 167, 0, 1, 90, 1'b0);
        add_item(ffse_pkg::ACT_SPARK, 168, 0, 5, 255, 1'b0);
        add_item(ffse_pkg::ACT_SPARK, 255, 127, 15, 255, 1'b0);
        add_item(ffse_pkg::ACT_SPARK, 50, 0, 0, 77, 1'b0);
        add_item(ffse_pkg::ACT_READ, 0, 100, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 167, 101, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 168, 101, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 5, 102, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_STEP, 0, 0, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_STEP, 0, 0, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 2, 98, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 1, 97, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 165, 96, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 255, 127, 15, 255, 1'b0);
        add_item(ffse_pkg::ACT_READ, 10, 103, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 169, 10, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_NONE, 255, 127, 15, 255, 1'b0);
        add_item(ffse_pkg::ACT_STEP, 0, 0, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 4, 95, 1, 0, 1'b0);
        add_item(ffse_pkg::ACT_READ, 0, 99, 1, 0, 1'b0);

        // Random: mostly spark-step-read sequences, the rest free-form noise.
        n_rand = 0;
        steps_left = 18;
        climbed = 3;
        drain_next = 1'b1;
        while (n_rand < 76) begin
            if (n_rand >= 50 && n_rand < 55) begin
                drain_next = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(1, 3);
                repeat (k) begin
                    add_item(ffse_pkg::ACT_SPARK, $urandom_range(0, COLS - 1),
                             $urandom_range(0, 127), $urandom_range(1, 10), hot_color(),
                             drain_next);
                    drain_next = 1'b0;
                    n_rand++;
                end
                if (steps_left > 0 && $urandom_range(0, 2) != 0) begin
                    k = $urandom_range(1, 2);
                    repeat (k) begin
                        if (steps_left > 0) begin
                            add_item(ffse_pkg::ACT_STEP, $urandom_range(0, 255),
                                     $urandom_range(0, 127), $urandom_range(0, 15),
                                     $urandom_range(0, 255), 1'b0);
                            steps_left--;
                            climbed++;
                            n_rand++;
                        end
                    end
                end
                k = $urandom_range(2, 5);
                repeat (k) begin
                    add_item(ffse_pkg::ACT_READ,
                             ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                          : $urandom_range(0, COLS - 1),
                             flame_row(climbed), $urandom_range(0, 15), $urandom_range(0, 255),
                             1'b0);
                    n_rand++;
                end
            end else begin
                act = ffse_pkg::action_t'($urandom_range(0, 3));
                if (act == ffse_pkg::ACT_STEP) begin
                    if (steps_left > 0) begin
                        steps_left--;
                        climbed++;
                    end else begin
                        act = ffse_pkg::ACT_READ;
                    end
                end
                add_item(act, $urandom_range(0, 255), $urandom_range(0, 127),
                         $urandom_range(0, 15), $urandom_range(0, 255), drain_next);
                drain_next = 1'b0;
                n_rand++;
            end
        end

        // Let everything drain, then give the block time to show any stray result.
        do begin
            @(posedge aclk);
        end while (item_backlog.size() != 0 || s_valid || value_due.size() != 0);
        repeat (50) @(posedge aclk);
        if (error_count == 0) begin
            $display("fire_field_stencil_engine_test: done, clean");
        end else begin
            $display("fire_field_stencil_engine_test: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/ffse_pkg.sv
hw/rtl/ffse_datapath.sv
hw/rtl/ffse_ctrl.sv
hw/rtl/fire_field_stencil_engine.sv
bench/fire_field_stencil_engine_test.sv
